[hw/rtl/rldec_pkg.sv]
// shared types and constants for the run-length delta run decoder
package rldec_pkg;

	localparam int WORD_W   = 16;
	localparam int LEFT_W   = 10;
	localparam int TOP_W    = 10;
	localparam int RWIDTH_W = 11;
	localparam int STRIDE_W = 11;
	localparam int INDEX_W  = 21;
	localparam int POS_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_STRIDE = 2'd3;

	localparam logic [RWIDTH_W-1:0] REGION_WIDTH_RST  = 11'd1;
	localparam logic [STRIDE_W-1:0] CANVAS_STRIDE_RST = 11'd640;

	typedef struct packed {
		logic [LEFT_W-1:0]   region_left;
		logic [TOP_W-1:0]    region_top;
		logic [RWIDTH_W-1:0] region_width;
		logic [STRIDE_W-1:0] canvas_stride;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] run_length;
		logic [WORD_W-1:0] delta_value;
		logic              frame_last;
	} run_item_t;

endpackage

[hw/rtl/rle_delta_run_decoder.sv]
// top level of the run-length delta run decoder
// a taken word passes the front end, the queue, the back end's divide and the result register,
//   and may wait for the back end or a free result slot
// the back end takes a new word only when done with the last one, held by the bit-serial
//   cursor divider that retires one quotient bit per cycle
// reset: config and control registers return to their reset values, frame state and queues cleared
module rle_delta_run_decoder #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [rldec_pkg::WORD_W-1:0]     code_word,
	input  logic                             frame_last,
	output logic                             empty,
	input  logic                             pop,
	output logic [rldec_pkg::INDEX_W-1:0]    pixel_index,
	output logic [rldec_pkg::POS_W-1:0]      run_col,
	output logic [rldec_pkg::POS_W-1:0]      run_row,
	output logic [rldec_pkg::WORD_W-1:0]     run_length,
	output logic [rldec_pkg::WORD_W-1:0]     delta_value,
	output logic                             frame_done,
	output logic                             row_overflow,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rldec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rldec_pkg::CFG_DATA_W-1:0] cfg_data
);

	rldec_pkg::cfg_t      cfg_q;
	rldec_pkg::run_item_t f_item;
	rldec_pkg::run_item_t b_item;
	logic                 f_push;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_left   <= '0;
			cfg_q.region_top    <= '0;
			cfg_q.region_width  <= rldec_pkg::REGION_WIDTH_RST;
			cfg_q.canvas_stride <= rldec_pkg::CANVAS_STRIDE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rldec_pkg::REG_REGION_LEFT: begin
					cfg_q.region_left <= cfg_data[rldec_pkg::LEFT_W-1:0];
				end
				rldec_pkg::REG_REGION_TOP: begin
					cfg_q.region_top <= cfg_data[rldec_pkg::TOP_W-1:0];
				end
				rldec_pkg::REG_REGION_WIDTH: begin
					cfg_q.region_width <= cfg_data[rldec_pkg::RWIDTH_W-1:0];
				end
				rldec_pkg::REG_CANVAS_STRIDE: begin
					cfg_q.canvas_stride <= cfg_data[rldec_pkg::STRIDE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rldec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (q_full),
		.code_word  (code_word),
		.frame_last (frame_last),
		.q_push     (f_push),
		.q_item     (f_item)
	);

	rldec_fifo #(
		.DEPTH (2)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_push),
		.wr_item (f_item),
		.full    (q_full),
		.rd      (q_pop),
		.rd_item (b_item),
		.empty   (q_empty)
	);

	rldec_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_item       (b_item),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.pixel_index  (pixel_index),
		.run_col      (run_col),
		.run_row      (run_row),
		.run_length   (run_length),
		.delta_value  (delta_value),
		.frame_done   (frame_done),
		.row_overflow (row_overflow)
	);

endmodule

[hw/rtl/rldec_front.sv]
// front end: classifies code words into literal runs and counted runs
module rldec_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        q_full,
	input  logic [rldec_pkg::WORD_W-1:0] code_word,
	input  logic                        frame_last,
	output logic                        q_push,
	output rldec_pkg::run_item_t        q_item
);

	logic [rldec_pkg::WORD_W-1:0] prev_q;
	logic                         cnt_exp_q;
	logic                         acc;

	assign acc    = push && !q_full;
	assign q_push = acc;

	always_comb begin
		q_item.frame_last = frame_last;
		if (cnt_exp_q) begin
			q_item.run_length  = code_word;
			q_item.delta_value = prev_q;
		end else begin
			q_item.run_length  = rldec_pkg::WORD_W'(1);
			q_item.delta_value = code_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			cnt_exp_q <= 1'b0;
		end else if (acc) begin
			if (frame_last) begin
				prev_q    <= '0;
				cnt_exp_q <= 1'b0;
			end else if (cnt_exp_q) begin
				cnt_exp_q <= 1'b0;
			end else begin
				cnt_exp_q <= (code_word == prev_q);
				prev_q    <= code_word;
			end
		end
	end

endmodule

[hw/rtl/rldec_fifo.sv]
// short queue of classified runs between front and back end
module rldec_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  rldec_pkg::run_item_t wr_item,
	output logic                 full,
	input  logic                 rd,
	output rldec_pkg::run_item_t rd_item,
	output logic                 empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rldec_pkg::run_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/rldec_back.sv]
// back end: cursor walk with bit-serial divider and descriptor output register
module rldec_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rldec_pkg::cfg_t               cfg,
	input  logic                          q_empty,
	input  rldec_pkg::run_item_t          q_item,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [rldec_pkg::INDEX_W-1:0] pixel_index,
	output logic [rldec_pkg::POS_W-1:0]   run_col,
	output logic [rldec_pkg::POS_W-1:0]   run_row,
	output logic [rldec_pkg::WORD_W-1:0]  run_length,
	output logic [rldec_pkg::WORD_W-1:0]  delta_value,
	output logic                          frame_done,
	output logic                          row_overflow
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_ROWS + 1);
	localparam int EXW  = (WW > rldec_pkg::RWIDTH_W) ? WW : rldec_pkg::RWIDTH_W;
	localparam int SW   = ((CW > rldec_pkg::WORD_W) ? CW : rldec_pkg::WORD_W) + 1;
	localparam int NW   = $clog2(SW + 1);
	localparam int AW   = ((RW > SW) ? RW : SW) + 1;
	localparam int RTW  = ((RW > rldec_pkg::TOP_W) ? RW : rldec_pkg::TOP_W) + 1;
	localparam int PW   = RTW + rldec_pkg::STRIDE_W;
	localparam int XW   = PW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    st_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [NW-1:0] step_q;
	logic          out_vld_q;

	logic [WW-1:0] ew_q;
	logic [SW-1:0] num_q;
	logic [WW-1:0] rem_q;
	logic [RTW-1:0] rt_q;
	logic [PW-1:0] prod_q;
	logic          ovf_q;
	rldec_pkg::run_item_t item_q;

	logic [EXW-1:0] w_ext;
	logic [WW-1:0]  w_eff;
	logic [WW:0]    rem_sh;
	logic           ge;
	logic [WW:0]    rem_sub;
	logic [AW-1:0]  row_sum;
	logic [RW-1:0]  row_nx;
	logic [XW-1:0]  idx_sum;
	logic [31:0]    col_ext;
	logic [31:0]    row_ext;
	logic           load_out;

	assign empty = !out_vld_q;
	assign q_pop = (st_q == ST_IDLE) && !q_empty;
	assign load_out = (st_q == ST_DONE) && (!out_vld_q || pop);

	always_comb begin
		w_ext = EXW'(cfg.region_width);
		if (w_ext == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > EXW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext[WW-1:0];
		end
	end

	assign rem_sh  = {rem_q, num_q[SW-1]};
	assign ge      = (rem_sh >= {1'b0, ew_q});
	assign rem_sub = ge ? (rem_sh - {1'b0, ew_q}) : rem_sh;

	always_comb begin
		row_sum = AW'(row_q) + AW'(num_q);
		if (row_sum > AW'(MAX_ROWS)) begin
			row_nx = RW'(MAX_ROWS);
		end else begin
			row_nx = row_sum[RW-1:0];
		end
	end

	assign idx_sum = XW'(prod_q) + XW'(cfg.region_left) + XW'(col_q);
	assign col_ext = 32'(col_q);
	assign row_ext = 32'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						step_q <= '0;
						st_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == NW'(SW - 1)) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						st_q <= ST_IDLE;
						if (item_q.frame_last) begin
							col_q <= '0;
							row_q <= '0;
						end else begin
							col_q <= rem_q[CW-1:0];
							row_q <= row_nx;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			ew_q   <= w_eff;
			num_q  <= SW'(col_q) + SW'(q_item.run_length);
			rem_q  <= '0;
			rt_q   <= RTW'(cfg.region_top) + RTW'(row_q);
			ovf_q  <= (row_q >= RW'(MAX_ROWS));
		end
		if (st_q == ST_DIV) begin
			num_q  <= {num_q[SW-2:0], ge};
			rem_q  <= rem_sub[WW-1:0];
			prod_q <= rt_q * cfg.canvas_stride;
		end
		if (load_out) begin
			run_length   <= item_q.run_length;
			delta_value  <= item_q.delta_value;
			frame_done   <= item_q.frame_last;
			row_overflow <= ovf_q;
			if (ovf_q) begin
				pixel_index <= '0;
				run_col     <= '0;
				run_row     <= '0;
			end else begin
				pixel_index <= idx_sum[rldec_pkg::INDEX_W-1:0];
				run_col     <= col_ext[rldec_pkg::POS_W-1:0];
				run_row     <= row_ext[rldec_pkg::POS_W-1:0];
			end
		end
	end

endmodule

[tb/tb_rle_delta_run_decoder.sv]
// self-checking testbench for the run-length delta run decoder
`timescale 1ns / 100ps

module tb_rle_delta_run_decoder;
	import rldec_pkg::*;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int SETTLE    = 40;
	localparam int LIMIT     = 600000;
	localparam int FIXED_PHASES  = 5;
	localparam int RANDOM_PHASES = 15;

	typedef struct packed {
		logic [INDEX_W-1:0] pixel_index;
		logic [POS_W-1:0]   run_col;
		logic [POS_W-1:0]   run_row;
		logic [WORD_W-1:0]  run_length;
		logic [WORD_W-1:0]  delta_value;
		logic               frame_done;
		logic               row_overflow;
	} run_desc_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
		logic              typed;
		run_desc_t         want;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [WORD_W-1:0]     code_word;
	logic                  frame_last;
	logic                  empty;
	logic                  pop;
	logic [INDEX_W-1:0]    pixel_index;
	logic [POS_W-1:0]      run_col;
	logic [POS_W-1:0]      run_row;
	logic [WORD_W-1:0]     run_length;
	logic [WORD_W-1:0]     delta_value;
	logic                  frame_done;
	logic                  row_overflow;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic      typed_now;
	run_desc_t typed_want;
	step_t     directed_steps [13];
	run_desc_t pending_runs [$];
	bit        failed;
	bit        steady;
	int        cycles;

	logic [LEFT_W-1:0]   cfg_left;
	logic [TOP_W-1:0]    cfg_top;
	logic [RWIDTH_W-1:0] cfg_width;
	logic [STRIDE_W-1:0] cfg_stride;
	logic [WORD_W-1:0]   prev_literal;
	bit                  count_due;
	int unsigned         cur_col;
	int unsigned         cur_row;

	rle_delta_run_decoder #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_ROWS (MAX_ROWS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.code_word   (code_word),
		.frame_last  (frame_last),
		.empty       (empty),
		.pop         (pop),
		.pixel_index (pixel_index),
		.run_col     (run_col),
		.run_row     (run_row),
		.run_length  (run_length),
		.delta_value (delta_value),
		.frame_done  (frame_done),
		.row_overflow(row_overflow),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic run_desc_t decode_word(input logic [WORD_W-1:0] w, input logic l);
		run_desc_t   r;
		int unsigned len;
		int unsigned span;
		int unsigned sum;
		logic [31:0] idx;
		r = '0;
		r.row_overflow = (cur_row >= MAX_ROWS);
		if (!r.row_overflow) begin
			idx = (32'(cfg_top) + cur_row) * 32'(cfg_stride) + 32'(cfg_left) + cur_col;
			r.pixel_index = idx[INDEX_W-1:0];
			r.run_col = cur_col[POS_W-1:0];
			r.run_row = cur_row[POS_W-1:0];
		end
		if (count_due) begin
			len = w;
			r.delta_value = prev_literal;
			count_due = 1'b0;
		end else begin
			len = 1;
			r.delta_value = w;
			count_due = (w == prev_literal);
			prev_literal = w;
		end
		r.run_length = len[WORD_W-1:0];
		r.frame_done = l;
		span = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
		sum = cur_col + len;
		cur_row = cur_row + sum / span;
		cur_col = sum % span;
		if (cur_row > MAX_ROWS)
			cur_row = MAX_ROWS;
		if (l) begin
			prev_literal = '0;
			count_due = 1'b0;
			cur_col = 0;
			cur_row = 0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin : monitor
		run_desc_t want;
		cycles = cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else if (arst_n) begin
			if (pop && !empty) begin
				if (pending_runs.size() == 0) begin
					$error("run descriptor beat with none expected");
					failed = 1'b1;
				end else begin
					want = pending_runs.pop_front();
					check_field("pixel_index", want.pixel_index, pixel_index);
					check_field("run_col", want.run_col, run_col);
					check_field("run_row", want.run_row, run_row);
					check_field("run_length", want.run_length, run_length);
					check_field("delta_value", want.delta_value, delta_value);
					check_field("frame_done", want.frame_done, frame_done);
					check_field("row_overflow", want.row_overflow, row_overflow);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_REGION_LEFT:   cfg_left = cfg_data[LEFT_W-1:0];
					REG_REGION_TOP:    cfg_top = cfg_data[TOP_W-1:0];
					REG_REGION_WIDTH:  cfg_width = cfg_data[RWIDTH_W-1:0];
					REG_CANVAS_STRIDE: cfg_stride = cfg_data[STRIDE_W-1:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				want = decode_word(code_word, frame_last);
				if (typed_now)
					want = typed_want;
				pending_runs.push_back(want);
			end
		end
	end

	initial begin : result_side
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w, input logic l, input logic typed,
		input run_desc_t want);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		code_word <= w;
		frame_last <= l;
		typed_now <= typed;
		typed_want <= want;
		do @(posedge clk); while (full);
	endtask

	task automatic drain_runs;
		push <= 1'b0;
		@(posedge clk);
		while (pending_runs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_config(input logic [10:0] left, input logic [10:0] top,
		input logic [10:0] width, input logic [10:0] stride);
		put_reg(REG_REGION_LEFT, left);
		put_reg(REG_REGION_TOP, top);
		put_reg(REG_REGION_WIDTH, width);
		put_reg(REG_CANVAS_STRIDE, stride);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [10:0] pick_reg_value(input bit narrow);
		case ($urandom_range(0, 7))
			0: return 11'h7FF;
			1: return 11'h000;
			2, 3, 4: return narrow ? 11'($urandom_range(1, 64)) : 11'($urandom_range(0, 2047));
			default: return 11'($urandom_range(0, 2047));
		endcase
	endfunction

	// mostly well-formed frames: repeats force a count word next, with some noise mixed in
	task automatic send_frames(input int count);
		logic [WORD_W-1:0] last_lit;
		logic [WORD_W-1:0] w;
		bit                count_next;
		logic              l;
		int unsigned       span;
		last_lit = '0;
		count_next = 1'b0;
		for (int n = 0; n < count; n++) begin
			span = (cfg_width == 0) ? 1 : cfg_width;
			if (count_next) begin
				case ($urandom_range(0, 9))
					0, 1: w = 16'($urandom_range(0, 3));
					2, 3, 4, 5, 6: w = 16'($urandom_range(0, (span * 3 > 65535) ? 65535 : span * 3));
					7, 8: w = 16'($urandom);
					default: w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				endcase
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: w = last_lit;
					3: w = 16'h0000;
					default: w = 16'($urandom);
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				w = 16'($urandom);
			l = (n == count - 1) || ($urandom_range(0, 39) == 0);
			if (count_next) begin
				count_next = 1'b0;
			end else begin
				count_next = (w == last_lit);
				last_lit = w;
			end
			if (l) begin
				last_lit = '0;
				count_next = 1'b0;
			end
			send_word(w, l, 1'b0, '0);
		end
	endtask

	initial begin
		logic [10:0] left;
		logic [10:0] top;
		logic [10:0] width;
		logic [10:0] stride;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		code_word = '0;
		frame_last = 1'b0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_REGION_LEFT;
		cfg_data = '0;
		typed_now = 1'b0;
		typed_want = '0;
		failed = 1'b0;
		steady = 1'b0;
		cycles = 0;
		cfg_left = '0;
		cfg_top = '0;
		cfg_width = REGION_WIDTH_RST;
		cfg_stride = CANVAS_STRIDE_RST;
		prev_literal = '0;
		count_due = 1'b0;
		cur_col = 0;
		cur_row = 0;

		// word, last, typed, then index, col, row, length, delta, done, overflow
		directed_steps[0]  = {16'h0000, 1'b0, 1'b1,
			21'd0, 10'd0, 10'd0, 16'd1, 16'h0000, 1'b0, 1'b0};
		// zero count leaves the cursor in place
		directed_steps[1]  = {16'h0000, 1'b0, 1'b1,
			21'd640, 10'd0, 10'd1, 16'd0, 16'h0000, 1'b0, 1'b0};
		directed_steps[2]  = {16'hFFFF, 1'b0, 1'b1,
			21'd640, 10'd0, 10'd1, 16'd1, 16'hFFFF, 1'b0, 1'b0};
		directed_steps[3]  = {16'hFFFF, 1'b0, 1'b1,
			21'd1280, 10'd0, 10'd2, 16'd1, 16'hFFFF, 1'b0, 1'b0};
		// largest count saturates the row
		directed_steps[4]  = {16'hFFFF, 1'b0, 1'b1,
			21'd1920, 10'd0, 10'd3, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0};
		directed_steps[5]  = {16'h1234, 1'b0, 1'b1,
			21'd0, 10'd0, 10'd0, 16'd1, 16'h1234, 1'b0, 1'b1};
		// frame closes on a repeat that would make a count due
		directed_steps[6]  = {16'h1234, 1'b1, 1'b1,
			21'd0, 10'd0, 10'd0, 16'd1, 16'h1234, 1'b1, 1'b1};
		directed_steps[7]  = {16'h5555, 1'b0, 1'b1,
			21'd0, 10'd0, 10'd0, 16'd1, 16'h5555, 1'b0, 1'b0};
		directed_steps[8]  = {16'hAAAA, 1'b1, 1'b1,
			21'd640, 10'd0, 10'd1, 16'd1, 16'hAAAA, 1'b1, 1'b0};
		directed_steps[9]  = {16'h0007, 1'b0, 1'b0, 75'd0};
		directed_steps[10] = {16'h0007, 1'b0, 1'b0, 75'd0};
		directed_steps[11] = {16'h0001, 1'b0, 1'b0, 75'd0};
		directed_steps[12] = {16'h8000, 1'b1, 1'b0, 75'd0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i])
			send_word(directed_steps[i].word, directed_steps[i].last,
				directed_steps[i].typed, directed_steps[i].want);
		drain_runs();

		for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
			case (p)
				// out-of-range bits, zero width and zero stride
				0: begin left = 11'h7FF; top = 11'h7FF; width = 11'd0; stride = 11'd0; end
				// oversized width and stride, index wraps
				1: begin left = 11'd1023; top = 11'd1023; width = 11'h7FF; stride = 11'h7FF; end
				2: begin left = 11'd0; top = 11'd0; width = 11'd1024; stride = 11'd1024; end
				3: begin left = 11'd3; top = 11'd1; width = 11'd1; stride = 11'd1; end
				4: begin left = 11'd17; top = 11'd9; width = 11'd5; stride = 11'd640; end
				default: begin
					left = pick_reg_value(1'b0);
					top = pick_reg_value(1'b0);
					width = pick_reg_value(1'b1);
					stride = pick_reg_value(1'b0);
				end
			endcase
			write_config(left, top, width, stride);
			steady = (p > 1) && ($urandom_range(0, 3) == 0);
			send_frames(p < FIXED_PHASES ? 40 : 110);
			drain_runs();
		end

		if (!failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
